>>> hw/rtl/cpu8alu_pkg.sv
`timescale 1ns / 1ps
// Shared definitions for the 8-bit CPU ALU: operation codes and flag positions.
// No dependencies; the top level and the testbench import it.

package cpu8alu_pkg;

   typedef enum logic [3:0] {
      MODE_ADD   = 4'd0,
      MODE_ADC   = 4'd1,
      MODE_SUB   = 4'd2,
      MODE_SBC   = 4'd3,
      MODE_AND   = 4'd4,
      MODE_XOR   = 4'd5,
      MODE_OR    = 4'd6,
      MODE_CP    = 4'd7,
      MODE_DAA   = 4'd8,
      MODE_CPL   = 4'd9,
      MODE_SCF   = 4'd10,
      MODE_CCF   = 4'd11,
      MODE_ADD16 = 4'd12,
      MODE_SPOFS = 4'd13
   } mode_type;

   // Bit positions in the flag nibble.
   localparam int FLAG_Z = 3;
   localparam int FLAG_N = 2;
   localparam int FLAG_H = 1;
   localparam int FLAG_C = 0;

   localparam logic [7:0] DAA_LIMIT   = 8'h99;
   localparam logic [7:0] DAA_HI_ADJ  = 8'h60;
   localparam logic [7:0] DAA_LO_ADJ  = 8'h06;
   localparam logic [3:0] DAA_LO_LIM  = 4'h9;

endpackage

>>> hw/rtl/cpu8alu_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the 8-bit CPU ALU request and response.
// Depends on nothing; it does not use the ALU package.

interface cpu8alu_req_if;
   logic        valid;
   logic        ready;
   logic [3:0]  mode;
   logic [7:0]  acc;
   logic [7:0]  operand;
   logic [15:0] wide_base;
   logic [15:0] wide_operand;
   logic [3:0]  flags_in;

   modport source (output valid, mode, acc, operand, wide_base, wide_operand, flags_in,
                   input ready);
   modport sink   (input valid, mode, acc, operand, wide_base, wide_operand, flags_in,
                   output ready);
endinterface

interface cpu8alu_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] result;
   logic [3:0]  flags_out;

   modport source (output valid, result, flags_out, input ready);
   modport sink   (input valid, result, flags_out, output ready);
endinterface

>>> hw/rtl/cpu8_alu_flags.sv
`timescale 1ns / 1ps
// Three-stage pipelined ALU of an 8-bit accumulator CPU with flag generation.
// Depends on cpu8alu_pkg and the channel interfaces in cpu8alu_if.sv.
//
//   channel    direction  contents
//   req_chan   in         mode, acc, operand, wide_base, wide_operand, flags_in
//   rsp_chan   out        result, flags_out
//
// Each transaction passes the stages in order: low nibbles and decimal pre-adjust,
// then the upper adder nibbles and flag selection, then the top wide nibble, zero
// detect and the response register. One transaction enters per cycle unless stalled.
// Each stage has its own valid bit and holds while the stage after it is full and
// stalled, so bubbles close up behind a stalled response. Reset clears the valid bits.

module cpu8_alu_flags (
   input logic          clock,
   input logic          reset,
   cpu8alu_req_if.sink   req_chan,
   cpu8alu_rsp_if.source rsp_chan
);
   import cpu8alu_pkg::*;

   typedef struct packed {
      mode_type    mode;
      logic [7:0]  acc;
      logic [7:0]  b_eff;
      logic [4:0]  lo;
      logic [7:0]  logic_res;
      logic [15:0] wb;
      logic [15:0] wop;
      logic [4:0]  wlo;
      logic [3:0]  fi;
      logic [7:0]  daa_v;
      logic        daa_c;
   } s1_type;

   typedef struct packed {
      mode_type    mode;
      logic [7:0]  r8;
      logic [7:0]  zv;
      logic        zres;
      logic [3:0]  fl;
      logic [11:0] wlo12;
      logic [3:0]  wb_hi;
      logic [3:0]  wop_hi;
      logic        c12;
   } s2_type;

   typedef struct packed {
      logic [15:0] result;
      logic [3:0]  flags;
   } s3_type;

   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   s3_type s3_ff, s3_in;
   logic   s1_v_ff, s2_v_ff, s3_v_ff;
   logic   adv1, adv2, adv3;

   mode_type   a_mode;
   logic       a_sub;
   logic       a_cin;
   logic       a_ci;
   logic       a_adj;
   logic [4:0] b_hi;
   logic [4:0] b_w2;
   logic [4:0] b_w3;
   logic [7:0] b_sum;
   logic [7:0] b_daa;
   logic [4:0] c_whi;

   // A stage moves forward when it is empty or the next stage moves.
   assign adv3 = !s3_v_ff || rsp_chan.ready;
   assign adv2 = !s2_v_ff || adv3;
   assign adv1 = !s1_v_ff || adv2;
   assign req_chan.ready = adv1;

   // Stage 1: operand conditioning, low nibble adds, logic ops, decimal pre-adjust.
   always_comb begin
      a_mode = mode_type'(req_chan.mode);
      a_sub  = (a_mode == MODE_SUB) || (a_mode == MODE_SBC) || (a_mode == MODE_CP);
      a_cin  = ((a_mode == MODE_ADC) || (a_mode == MODE_SBC)) && req_chan.flags_in[FLAG_C];
      // Subtraction runs as a + ~b + ~cin; the carry out is the inverted borrow.
      a_ci   = a_sub ? !a_cin : a_cin;

      s1_in.mode  = a_mode;
      s1_in.acc   = req_chan.acc;
      s1_in.fi    = req_chan.flags_in;
      s1_in.b_eff = a_sub ? ~req_chan.operand : req_chan.operand;
      s1_in.lo    = {1'b0, req_chan.acc[3:0]} + {1'b0, s1_in.b_eff[3:0]} + {4'b0, a_ci};

      s1_in.wb  = req_chan.wide_base;
      s1_in.wop = (a_mode == MODE_SPOFS) ? {{8{req_chan.operand[7]}}, req_chan.operand}
                                         : req_chan.wide_operand;
      s1_in.wlo = {1'b0, s1_in.wb[3:0]} + {1'b0, s1_in.wop[3:0]};

      unique case (a_mode)
         MODE_AND: s1_in.logic_res = req_chan.acc & req_chan.operand;
         MODE_XOR: s1_in.logic_res = req_chan.acc ^ req_chan.operand;
         default:  s1_in.logic_res = req_chan.acc | req_chan.operand;
      endcase

      // The high adjust leaves the low nibble alone, so the low test can wait.
      a_adj = req_chan.flags_in[FLAG_C] || (req_chan.acc > DAA_LIMIT);
      if (req_chan.flags_in[FLAG_N]) begin
         s1_in.daa_v = req_chan.flags_in[FLAG_C] ? req_chan.acc - DAA_HI_ADJ : req_chan.acc;
         s1_in.daa_c = req_chan.flags_in[FLAG_C];
      end else begin
         s1_in.daa_v = a_adj ? req_chan.acc + DAA_HI_ADJ : req_chan.acc;
         s1_in.daa_c = a_adj;
      end
   end

   // Stage 2: upper nibble of the byte adder, middle nibbles of the wide adder,
   // second decimal adjust and per-operation flag selection.
   always_comb begin
      b_hi  = {1'b0, s1_ff.acc[7:4]} + {1'b0, s1_ff.b_eff[7:4]} + {4'b0, s1_ff.lo[4]};
      b_sum = {b_hi[3:0], s1_ff.lo[3:0]};
      b_w2  = {1'b0, s1_ff.wb[7:4]} + {1'b0, s1_ff.wop[7:4]} + {4'b0, s1_ff.wlo[4]};
      b_w3  = {1'b0, s1_ff.wb[11:8]} + {1'b0, s1_ff.wop[11:8]} + {4'b0, b_w2[4]};

      if (s1_ff.fi[FLAG_N]) begin
         b_daa = s1_ff.fi[FLAG_H] ? s1_ff.daa_v - DAA_LO_ADJ : s1_ff.daa_v;
      end else if (s1_ff.fi[FLAG_H] || (s1_ff.daa_v[3:0] > DAA_LO_LIM)) begin
         b_daa = s1_ff.daa_v + DAA_LO_ADJ;
      end else begin
         b_daa = s1_ff.daa_v;
      end

      s2_in.mode   = s1_ff.mode;
      s2_in.wlo12  = {b_w3[3:0], b_w2[3:0], s1_ff.wlo[3:0]};
      s2_in.wb_hi  = s1_ff.wb[15:12];
      s2_in.wop_hi = s1_ff.wop[15:12];
      s2_in.c12    = b_w3[4];
      s2_in.zv     = b_sum;
      s2_in.zres   = 1'b0;
      s2_in.r8     = s1_ff.acc;
      s2_in.fl     = s1_ff.fi;

      unique case (s1_ff.mode)
         MODE_ADD, MODE_ADC: begin
            s2_in.r8   = b_sum;
            s2_in.zres = 1'b1;
            s2_in.fl   = {1'b0, 1'b0, s1_ff.lo[4], b_hi[4]};
         end
         MODE_SUB, MODE_SBC, MODE_CP: begin
            if (s1_ff.mode != MODE_CP) begin
               s2_in.r8 = b_sum;
            end
            s2_in.zres = 1'b1;
            s2_in.fl   = {1'b0, 1'b1, !s1_ff.lo[4], !b_hi[4]};
         end
         MODE_AND: begin
            s2_in.r8   = s1_ff.logic_res;
            s2_in.zv   = s1_ff.logic_res;
            s2_in.zres = 1'b1;
            s2_in.fl   = 4'b0010;
         end
         MODE_XOR, MODE_OR: begin
            s2_in.r8   = s1_ff.logic_res;
            s2_in.zv   = s1_ff.logic_res;
            s2_in.zres = 1'b1;
            s2_in.fl   = 4'b0000;
         end
         MODE_DAA: begin
            s2_in.r8   = b_daa;
            s2_in.zv   = b_daa;
            s2_in.zres = 1'b1;
            s2_in.fl   = {1'b0, s1_ff.fi[FLAG_N], 1'b0, s1_ff.daa_c};
         end
         MODE_CPL: begin
            s2_in.r8 = ~s1_ff.acc;
            s2_in.fl = {s1_ff.fi[FLAG_Z], 1'b1, 1'b1, s1_ff.fi[FLAG_C]};
         end
         MODE_SCF: s2_in.fl = {s1_ff.fi[FLAG_Z], 1'b0, 1'b0, 1'b1};
         MODE_CCF: s2_in.fl = {s1_ff.fi[FLAG_Z], 1'b0, 1'b0, !s1_ff.fi[FLAG_C]};
         // The carry of the register-pair add is filled in by the last stage.
         MODE_ADD16: s2_in.fl = {s1_ff.fi[FLAG_Z], 1'b0, b_w3[4], 1'b0};
         MODE_SPOFS: s2_in.fl = {1'b0, 1'b0, s1_ff.wlo[4], b_w2[4]};
         default: ;
      endcase
   end

   // Stage 3: top nibble of the wide adder, zero detect, result assembly.
   always_comb begin
      c_whi = {1'b0, s2_ff.wb_hi} + {1'b0, s2_ff.wop_hi} + {4'b0, s2_ff.c12};
      if ((s2_ff.mode == MODE_ADD16) || (s2_ff.mode == MODE_SPOFS)) begin
         s3_in.result = {c_whi[3:0], s2_ff.wlo12};
      end else begin
         s3_in.result = {8'h00, s2_ff.r8};
      end
      s3_in.flags = s2_ff.fl;
      if (s2_ff.zres) begin
         s3_in.flags[FLAG_Z] = (s2_ff.zv == 8'h00);
      end
      if (s2_ff.mode == MODE_ADD16) begin
         s3_in.flags[FLAG_C] = c_whi[4];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         if (adv1) s1_v_ff <= req_chan.valid;
         if (adv2) s2_v_ff <= s1_v_ff;
         if (adv3) s3_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1 && req_chan.valid) s1_ff <= s1_in;
      if (adv2 && s1_v_ff) s2_ff <= s2_in;
      if (adv3 && s2_v_ff) s3_ff <= s3_in;
   end

   assign rsp_chan.valid     = s3_v_ff;
   assign rsp_chan.result    = s3_ff.result;
   assign rsp_chan.flags_out = s3_ff.flags;

endmodule

>>> tb/tb_cpu8_alu_flags.sv
`timescale 1ns / 1ps
// Self-checking testbench for the cpu8_alu_flags pipelined ALU, with directed and random ops.
// Depends on cpu8alu_pkg, the channel interfaces in cpu8alu_if.sv and the cpu8_alu_flags RTL.

module tb_cpu8_alu_flags;
   import cpu8alu_pkg::*;

   // Codes 14 and 15 are not assigned to any operation.
   localparam logic [3:0] MODE_SPARE_14 = 4'd14;
   localparam logic [3:0] MODE_SPARE_15 = 4'd15;
   localparam int QUIET_LIMIT  = 2000;
   localparam int RANDOM_OPS   = 1000;
   localparam int PHASE_COUNT  = 4;

   typedef struct packed {
      logic [3:0]  mode;
      logic [7:0]  acc;
      logic [7:0]  operand;
      logic [15:0] wide_base;
      logic [15:0] wide_operand;
      logic [3:0]  flags_in;
   } alu_op_type;

   typedef struct packed {
      logic [15:0] result;
      logic [3:0]  flags_out;
   } alu_rsp_type;

   typedef struct {
      alu_op_type  op;
      bit          typed;
      alu_rsp_type rsp;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset;

   cpu8alu_req_if req_chan ();
   cpu8alu_rsp_if rsp_chan ();

   cpu8_alu_flags u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Travel alongside each request so the monitor knows whether a row carries a typed result.
   logic        row_typed;
   alu_rsp_type row_rsp;

   int          send_idle_pct;
   int          rsp_stall_pct;
   int          fail_count = 0;
   int          quiet_cycles = 0;
   alu_rsp_type alu_results_due[$];
   dir_row_type dir_rows[$];

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic alu_rsp_type alu_outcome(input alu_op_type op);
      alu_rsp_type r;
      logic [8:0]  sum8;
      logic [4:0]  nib;
      logic [16:0] sum16;
      logic [12:0] sum12;
      logic [7:0]  v;
      logic        cin;
      logic        cdaa;
      logic [3:0]  fo;
      logic [15:0] res;
      cin = op.flags_in[FLAG_C];
      fo  = op.flags_in;
      res = {8'h00, op.acc};
      case (op.mode)
         MODE_ADD, MODE_ADC: begin
            if (op.mode == MODE_ADD) cin = 1'b0;
            sum8 = {1'b0, op.acc} + {1'b0, op.operand} + 9'(cin);
            nib  = {1'b0, op.acc[3:0]} + {1'b0, op.operand[3:0]} + 5'(cin);
            res  = {8'h00, sum8[7:0]};
            fo   = '0;
            fo[FLAG_Z] = (sum8[7:0] == 8'h00);
            fo[FLAG_H] = nib[4];
            fo[FLAG_C] = sum8[8];
         end
         MODE_SUB, MODE_SBC, MODE_CP: begin
            if (op.mode != MODE_SBC) cin = 1'b0;
            // Bit 8 and bit 4 of the widened differences are the borrows.
            sum8 = {1'b0, op.acc} - {1'b0, op.operand} - 9'(cin);
            nib  = {1'b0, op.acc[3:0]} - {1'b0, op.operand[3:0]} - 5'(cin);
            if (op.mode != MODE_CP) res = {8'h00, sum8[7:0]};
            fo   = '0;
            fo[FLAG_Z] = (sum8[7:0] == 8'h00);
            fo[FLAG_N] = 1'b1;
            fo[FLAG_H] = nib[4];
            fo[FLAG_C] = sum8[8];
         end
         MODE_AND, MODE_XOR, MODE_OR: begin
            if (op.mode == MODE_AND) v = op.acc & op.operand;
            else if (op.mode == MODE_XOR) v = op.acc ^ op.operand;
            else v = op.acc | op.operand;
            res = {8'h00, v};
            fo  = '0;
            fo[FLAG_Z] = (v == 8'h00);
            fo[FLAG_H] = (op.mode == MODE_AND);
         end
         MODE_DAA: begin
            v    = op.acc;
            cdaa = cin;
            if (op.flags_in[FLAG_N]) begin
               if (op.flags_in[FLAG_C]) v = v - DAA_HI_ADJ;
               if (op.flags_in[FLAG_H]) v = v - DAA_LO_ADJ;
            end else begin
               if (cdaa || v > DAA_LIMIT) begin
                  v    = v + DAA_HI_ADJ;
                  cdaa = 1'b1;
               end
               if (op.flags_in[FLAG_H] || v[3:0] > DAA_LO_LIM) v = v + DAA_LO_ADJ;
            end
            res = {8'h00, v};
            fo  = '0;
            fo[FLAG_Z] = (v == 8'h00);
            fo[FLAG_N] = op.flags_in[FLAG_N];
            fo[FLAG_C] = cdaa;
         end
         MODE_CPL: begin
            res = {8'h00, ~op.acc};
            fo[FLAG_N] = 1'b1;
            fo[FLAG_H] = 1'b1;
         end
         MODE_SCF, MODE_CCF: begin
            fo[FLAG_N] = 1'b0;
            fo[FLAG_H] = 1'b0;
            fo[FLAG_C] = (op.mode == MODE_SCF) ? 1'b1 : ~cin;
         end
         MODE_ADD16: begin
            sum16 = {1'b0, op.wide_base} + {1'b0, op.wide_operand};
            sum12 = {1'b0, op.wide_base[11:0]} + {1'b0, op.wide_operand[11:0]};
            res   = sum16[15:0];
            fo[FLAG_N] = 1'b0;
            fo[FLAG_H] = sum12[12];
            fo[FLAG_C] = sum16[16];
         end
         MODE_SPOFS: begin
            // Carries come from the unsigned low byte; the sum uses the sign-extended offset.
            res  = op.wide_base + {{8{op.operand[7]}}, op.operand};
            nib  = {1'b0, op.wide_base[3:0]} + {1'b0, op.operand[3:0]};
            sum8 = {1'b0, op.wide_base[7:0]} + {1'b0, op.operand};
            fo   = '0;
            fo[FLAG_H] = nib[4];
            fo[FLAG_C] = sum8[8];
         end
         default: begin
         end
      endcase
      r.result    = res;
      r.flags_out = fo;
      return r;
   endfunction

   function automatic logic [7:0] pick_byte();
      if ($urandom_range(3) != 0) return 8'($urandom_range(255));
      case ($urandom_range(5))
         0: return 8'h00;
         1: return 8'hFF;
         2: return 8'h0F;
         3: return 8'h80;
         4: return 8'h99;
         default: return 8'h7F;
      endcase
   endfunction

   function automatic logic [15:0] pick_word();
      if ($urandom_range(3) != 0) return 16'($urandom_range(65535));
      case ($urandom_range(4))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'h0FFF;
         3: return 16'h8000;
         default: return 16'h7FFF;
      endcase
   endfunction

   function automatic alu_op_type random_op();
      alu_op_type op;
      op.mode         = 4'($urandom_range(15));
      op.acc          = pick_byte();
      op.operand      = pick_byte();
      op.wide_base    = pick_word();
      op.wide_operand = pick_word();
      op.flags_in     = 4'($urandom_range(15));
      return op;
   endfunction

   task automatic add_row(input logic [3:0] mode, input logic [7:0] acc,
                          input logic [7:0] operand, input logic [15:0] wbase,
                          input logic [15:0] wop, input logic [3:0] fin,
                          input bit typed, input logic [15:0] res, input logic [3:0] fout);
      dir_row_type row;
      row.op.mode         = mode;
      row.op.acc          = acc;
      row.op.operand      = operand;
      row.op.wide_base    = wbase;
      row.op.wide_operand = wop;
      row.op.flags_in     = fin;
      row.typed           = typed;
      row.rsp.result      = res;
      row.rsp.flags_out   = fout;
      dir_rows.push_back(row);
   endtask

   task automatic send_op(input alu_op_type op, input bit typed, input alu_rsp_type rsp);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.mode         <= op.mode;
      req_chan.acc          <= op.acc;
      req_chan.operand      <= op.operand;
      req_chan.wide_base    <= op.wide_base;
      req_chan.wide_operand <= op.wide_operand;
      req_chan.flags_in     <= op.flags_in;
      row_typed             <= typed;
      row_rsp               <= rsp;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // Hold the request side quiet until every outstanding transaction has come back.
   task automatic drain_pipeline();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (alu_results_due.size() != 0);
   endtask

   always @(posedge clock) begin
      alu_op_type  seen;
      alu_rsp_type want;
      if (!reset && req_chan.valid && req_chan.ready) begin
         seen.mode         = req_chan.mode;
         seen.acc          = req_chan.acc;
         seen.operand      = req_chan.operand;
         seen.wide_base    = req_chan.wide_base;
         seen.wide_operand = req_chan.wide_operand;
         seen.flags_in     = req_chan.flags_in;
         alu_results_due.push_back(row_typed ? row_rsp : alu_outcome(seen));
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (alu_results_due.size() == 0) begin
            $error("unexpected transaction: result %h flags_out %h",
                   rsp_chan.result, rsp_chan.flags_out);
            fail_count++;
         end else begin
            want = alu_results_due.pop_front();
            if (rsp_chan.result !== want.result) begin
               $error("result: expected %h, actual %h", want.result, rsp_chan.result);
               fail_count++;
            end
            if (rsp_chan.flags_out !== want.flags_out) begin
               $error("flags_out: expected %h, actual %h", want.flags_out, rsp_chan.flags_out);
               fail_count++;
            end
         end
      end
      rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.mode         = '0;
      req_chan.acc          = '0;
      req_chan.operand      = '0;
      req_chan.wide_base    = '0;
      req_chan.wide_operand = '0;
      req_chan.flags_in     = '0;
      row_typed             = 1'b0;
      row_rsp               = '0;
      send_idle_pct         = 0;
      rsp_stall_pct         = 0;

      //      mode           acc    opnd   wbase     wop       fin   typed result    flags
      add_row(MODE_ADD,      8'h00, 8'h00, 16'h0000, 16'h0000, 4'h0, 1'b1, 16'h0000, 4'h8);
      add_row(MODE_ADD,      8'hFF, 8'h01, 16'h0000, 16'h0000, 4'h0, 1'b1, 16'h0000, 4'hB);
      add_row(MODE_ADD,      8'h0F, 8'h01, 16'h0000, 16'h0000, 4'h0, 1'b1, 16'h0010, 4'h2);
      add_row(MODE_ADC,      8'hFF, 8'h00, 16'h0000, 16'h0000, 4'h1, 1'b1, 16'h0000, 4'hB);
      add_row(MODE_ADC,      8'h7F, 8'h80, 16'h0000, 16'h0000, 4'hF, 1'b0, 16'h0000, 4'h0);
      add_row(MODE_SUB,      8'h00, 8'h01, 16'h0000, 16'h0000, 4'h0, 1'b1, 16'h00FF, 4'h7);
      add_row(MODE_SUB,      8'h55, 8'h55, 16'h0000, 16'h0000, 4'h0, 1'b1, 16'h0000, 4'hC);
      add_row(MODE_SBC,      8'h00, 8'h00, 16'h0000, 16'h0000, 4'h1, 1'b1, 16'h00FF, 4'h7);
      add_row(MODE_SBC,      8'h80, 8'h7F, 16'h0000, 16'h0000, 4'hF, 1'b0, 16'h0000, 4'h0);
      add_row(MODE_AND,      8'hF0, 8'h0F, 16'h0000, 16'h0000, 4'h0, 1'b1, 16'h0000, 4'hA);
      add_row(MODE_AND,      8'hFF, 8'hFF, 16'h0000, 16'h0000, 4'h0, 1'b1, 16'h00FF, 4'h2);
      add_row(MODE_XOR,      8'hFF, 8'hFF, 16'h0000, 16'h0000, 4'hF, 1'b1, 16'h0000, 4'h8);
      add_row(MODE_OR,       8'h00, 8'h00, 16'h0000, 16'h0000, 4'h7, 1'b1, 16'h0000, 4'h8);
      add_row(MODE_CP,       8'h3C, 8'h3C, 16'h0000, 16'h0000, 4'h0, 1'b1, 16'h003C, 4'hC);
      add_row(MODE_CP,       8'h00, 8'hFF, 16'h0000, 16'h0000, 4'h0, 1'b1, 16'h0000, 4'h7);
      add_row(MODE_DAA,      8'h9A, 8'h00, 16'h0000, 16'h0000, 4'h0, 1'b1, 16'h0000, 4'h9);
      add_row(MODE_DAA,      8'h00, 8'h00, 16'h0000, 16'h0000, 4'h7, 1'b0, 16'h0000, 4'h0);
      add_row(MODE_DAA,      8'h15, 8'h00, 16'h0000, 16'h0000, 4'h2, 1'b0, 16'h0000, 4'h0);
      add_row(MODE_CPL,      8'h00, 8'h00, 16'h0000, 16'h0000, 4'h9, 1'b1, 16'h00FF, 4'hF);
      add_row(MODE_SCF,      8'h42, 8'h00, 16'h0000, 16'h0000, 4'h8, 1'b1, 16'h0042, 4'h9);
      add_row(MODE_CCF,      8'h42, 8'h00, 16'h0000, 16'h0000, 4'hF, 1'b1, 16'h0042, 4'h8);
      add_row(MODE_ADD16,    8'h00, 8'h00, 16'hFFFF, 16'h0001, 4'h0, 1'b1, 16'h0000, 4'h3);
      add_row(MODE_ADD16,    8'h00, 8'h00, 16'h0FFF, 16'h0001, 4'h8, 1'b1, 16'h1000, 4'hA);
      add_row(MODE_SPOFS,    8'h00, 8'hFF, 16'h0000, 16'h0000, 4'hF, 1'b1, 16'hFFFF, 4'h0);
      add_row(MODE_SPOFS,    8'h00, 8'h01, 16'hFFFF, 16'h0000, 4'hF, 1'b1, 16'h0000, 4'h3);
      add_row(MODE_SPARE_14, 8'h77, 8'h00, 16'h0000, 16'h0000, 4'h5, 1'b1, 16'h0077, 4'h5);
      add_row(MODE_SPARE_15, 8'hFF, 8'hA5, 16'hFFFF, 16'hFFFF, 4'hA, 1'b1, 16'h00FF, 4'hA);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) send_op(dir_rows[i].op, dir_rows[i].typed, dir_rows[i].rsp);
      drain_pipeline();

      // Phases: back to back, sparse requests, heavy backpressure, then both at once.
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         send_idle_pct = (phase == 1) ? 83 : (phase == 3) ? 37 : 0;
         rsp_stall_pct = (phase == 2) ? 83 : (phase == 3) ? 37 : 0;
         repeat (RANDOM_OPS / PHASE_COUNT) send_op(random_op(), 1'b0, '0);
         drain_pipeline();
      end

      rsp_stall_pct = 0;
      repeat (8) @(posedge clock);
      if (alu_results_due.size() != 0)
         $error("%0d transactions never came back", alu_results_due.size());
      if ((fail_count == 0) && (alu_results_due.size() == 0))
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
